// ===== hdl/sfdl_pkg.sv =====
`timescale 1ns / 1ps

package sfdl_pkg;

  // Phase codes of the frame parser.
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_BYTE  = 2'd0;
  localparam logic [1:0] REG_PACKET_TYPE = 2'd1;
  localparam logic [1:0] REG_SENSOR_KIND = 2'd2;

  // Frame offsets of the captured bytes and the shortest frame that counts.
  localparam logic [8:0] OFS_TYPE    = 9'd7;
  localparam logic [8:0] OFS_KIND    = 9'd10;
  localparam logic [8:0] OFS_READING = 9'd13;
  localparam logic [8:0] MIN_FRAME   = 9'd14;
  localparam logic [8:0] LEN_EXTRA   = 9'd3;

  // floor(r * 544 / 100) = floor(r * 136 * 5243 / 2^17) for every 8-bit r.
  localparam logic [19:0] DIST_MUL   = 20'd713048;
  localparam int          DIST_SHIFT = 17;

  // Level thresholds.
  localparam logic [10:0] LVL_T1 = 11'd10;
  localparam logic [10:0] LVL_T2 = 11'd20;
  localparam logic [10:0] LVL_T3 = 11'd30;
  localparam logic [10:0] LVL_T4 = 11'd40;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] packet_type;
    logic [2:0] sensor_kind;
  } cfg_t;

  // One classified frame, handed from the parser to the distance stage.
  typedef struct packed {
    logic        updated;
    logic [10:0] distance;
  } evt_t;

  function automatic logic [2:0] bucket(input logic [10:0] d);
    logic [2:0] lvl;
    begin
      priority if (d <= LVL_T1) lvl = 3'd1;
      else if (d <= LVL_T2) lvl = 3'd2;
      else if (d <= LVL_T3) lvl = 3'd3;
      else if (d <= LVL_T4) lvl = 3'd4;
      else lvl = 3'd5;
      return lvl;
    end
  endfunction

endpackage

// ===== hdl/sfdl_front.sv =====
`timescale 1ns / 1ps

module sfdl_front (
  input  logic          clk,
  input  logic          rst_n,
  input  sfdl_pkg::cfg_t cfg,
  input  logic          byte_valid,
  input  logic [7:0]    rx_byte,
  output logic          evt_valid,
  output sfdl_pkg::evt_t evt
);
  import sfdl_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [7:0]  reading_r, reading_nxt;
  logic [9:0]  idx_inc;
  logic        last_byte;
  logic [27:0] prod;

  // Captured fields including the byte on hand this cycle.
  always_comb begin
    type_nxt    = (idx_r == OFS_TYPE)    ? rx_byte      : type_r;
    kind_nxt    = (idx_r == OFS_KIND)    ? rx_byte[2:0] : kind_r;
    reading_nxt = (idx_r == OFS_READING) ? rx_byte      : reading_r;
  end

  assign idx_inc   = {1'b0, idx_r} + 10'd1;
  assign last_byte = !(idx_inc < {1'b0, len_r});

  // Scaled reading by one constant multiply and a shift.
  assign prod = 28'(reading_nxt) * 28'(DIST_MUL);

  // Parser state step and frame classification.
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    evt_valid = 1'b0;
    evt.updated  = (kind_nxt == cfg.sensor_kind);
    evt.distance = prod[DIST_SHIFT +: 11];
    if (byte_valid) begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt   = {1'b0, rx_byte} + LEN_EXTRA;
          idx_nxt   = 9'd2;
          phase_nxt = PH_BODY;
        end
        PH_BODY: begin
          if (!last_byte) begin
            idx_nxt = idx_inc[8:0];
          end else begin
            phase_nxt = PH_HUNT;
            idx_nxt   = '0;
            evt_valid = (len_r >= MIN_FRAME) && (type_nxt == cfg.packet_type);
          end
        end
        default: begin
          if (rx_byte == cfg.start_byte) begin
            phase_nxt = PH_LEN;
            idx_nxt   = 9'd1;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      idx_r     <= '0;
      len_r     <= '0;
      type_r    <= '0;
      kind_r    <= '0;
      reading_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      if (byte_valid && phase_r == PH_BODY) begin
        type_r    <= type_nxt;
        kind_r    <= kind_nxt;
        reading_r <= reading_nxt;
      end
    end
  end

endmodule

// ===== hdl/sfdl_fifo.sv =====
`timescale 1ns / 1ps

module sfdl_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sfdl_pkg::evt_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output sfdl_pkg::evt_t pop_data
);
  import sfdl_pkg::*;

  evt_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hdl/sfdl_back.sv =====
`timescale 1ns / 1ps

module sfdl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           evt_avail,
  input  sfdl_pkg::evt_t evt,
  output logic           evt_take,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [2:0]     out_level,
  output logic [10:0]    out_distance,
  output logic           out_distance_updated
);
  import sfdl_pkg::*;

  logic        valid_r, valid_nxt;
  logic [10:0] last_r, last_nxt;
  logic [2:0]  level_r;
  logic [10:0] dist_r;
  logic        upd_r;

  // Take a frame whenever the result register is free or being drained.
  assign evt_take = evt_avail && (!valid_r || out_pop);

  always_comb begin
    last_nxt  = (evt_take && evt.updated) ? evt.distance : last_r;
    valid_nxt = evt_take || (valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (evt_take) begin
      level_r <= bucket(last_nxt);
      dist_r  <= last_nxt;
      upd_r   <= evt.updated;
    end
  end

  assign out_empty            = !valid_r;
  assign out_level            = level_r;
  assign out_distance         = dist_r;
  assign out_distance_updated = upd_r;

endmodule

// ===== hdl/sensor_frame_distance_level.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports
// --------  ---------  ------------------------------------------------------
// input     in         in_push, in_full, in_rx_byte
// result    out        out_empty, out_pop, out_level, out_distance,
//                      out_distance_updated
// config    in         cfg_we, cfg_index, cfg_wdata
//
// One byte is taken every cycle while in_full is low; the parser works on it in
// that cycle, and a frame's result is queued before the result register.
// The parser hands classified frames through a two-entry queue to the
// distance stage, which holds the stored distance and the result register.
// in_full rises only when that queue is full, which happens only while the
// result side is stalled. Reset (rst_n low, synchronous) restores register
// defaults, empties the queue and returns the parser to hunting.

module sensor_frame_distance_level (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_level,
  output logic [10:0] out_distance,
  output logic        out_distance_updated,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import sfdl_pkg::*;

  cfg_t cfg_r;
  logic byte_valid;
  logic evt_valid;
  evt_t evt_in;
  evt_t evt_out;
  logic fifo_empty;
  logic fifo_full;
  logic evt_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= 8'd2;
      cfg_r.packet_type <= 8'd1;
      cfg_r.sensor_kind <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_BYTE:  cfg_r.start_byte  <= cfg_wdata;
        REG_PACKET_TYPE: cfg_r.packet_type <= cfg_wdata;
        REG_SENSOR_KIND: cfg_r.sensor_kind <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign in_full    = fifo_full;
  assign byte_valid = in_push && !fifo_full;

  sfdl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (byte_valid),
    .rx_byte    (in_rx_byte),
    .evt_valid  (evt_valid),
    .evt        (evt_in)
  );

  sfdl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_valid),
    .push_data (evt_in),
    .full      (fifo_full),
    .pop       (evt_take),
    .empty     (fifo_empty),
    .pop_data  (evt_out)
  );

  sfdl_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .evt_avail            (!fifo_empty),
    .evt                  (evt_out),
    .evt_take             (evt_take),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_level            (out_level),
    .out_distance         (out_distance),
    .out_distance_updated (out_distance_updated)
  );

endmodule

// ===== sim/tb_sensor_frame_distance_level.sv =====
`timescale 1ns / 1ps

module tb_sensor_frame_distance_level;
  import sfdl_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;

  // One level report as the block should deliver it.
  typedef struct {
    logic [2:0]  level;
    logic [10:0] distance;
    logic        fresh;
  } level_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_level;
  logic [10:0] out_distance;
  logic        out_distance_updated;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_START_BYTE;
  logic [7:0]  cfg_wdata = 8'h00;

  // Bytes waiting to be offered, and level reports waiting to arrive.
  logic [7:0]    byte_q[$];
  level_report_t level_reports_due[$];

  // Register values the block holds, tracked from the write port.
  cfg_t shadow_cfg = '{start_byte: 8'd2, packet_type: 8'd1, sensor_kind: 3'd2};
  // Register values the stimulus is built for.
  cfg_t gen_cfg = '{start_byte: 8'd2, packet_type: 8'd1, sensor_kind: 3'd2};

  // Frame parser state of the predictor.
  logic [1:0]  fr_phase = PH_HUNT;
  logic [8:0]  fr_idx = '0;
  logic [8:0]  fr_len = '0;
  logic [7:0]  cap_type = '0;
  logic [2:0]  cap_kind = '0;
  logic [7:0]  cap_reading = '0;
  logic [10:0] stored_dist = '0;

  // Sender and receiver pacing.
  bit sender_steady = 1'b0;
  bit hold_request = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic [7:0] pop_mask = 8'hFF;
  logic [5:0] pat_pos = '0;

  int mismatch_count = 0;
  int reports_checked = 0;
  int fresh_readings = 0;
  int bytes_sent = 0;
  int full_stalls = 0;
  int queued_bytes = 0;
  int cycle_count = 0;

  sensor_frame_distance_level dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_rx_byte           (in_rx_byte),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_level            (out_level),
    .out_distance         (out_distance),
    .out_distance_updated (out_distance_updated),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Distance bucket: 1 up to the first threshold, 5 above the last.
  function automatic logic [2:0] level_of(input logic [10:0] d);
    if (d <= LVL_T1) return 3'd1;
    if (d <= LVL_T2) return 3'd2;
    if (d <= LVL_T3) return 3'd3;
    if (d <= LVL_T4) return 3'd4;
    return 3'd5;
  endfunction

  // Advance the frame parser by one byte and queue the report a frame end earns.
  function automatic void parse_rx_byte(input logic [7:0] b);
    level_report_t rpt;
    if (fr_phase == PH_LEN) begin
      fr_len = {1'b0, b} + LEN_EXTRA;
      fr_idx = 9'd2;
      fr_phase = PH_BODY;
    end else if (fr_phase != PH_BODY) begin
      if (b == shadow_cfg.start_byte) begin
        fr_phase = PH_LEN;
        fr_idx = 9'd1;
      end else begin
        fr_phase = PH_HUNT;
      end
    end else begin
      if (fr_idx == OFS_TYPE) cap_type = b;
      if (fr_idx == OFS_KIND) cap_kind = b[2:0];
      if (fr_idx == OFS_READING) cap_reading = b;
      if (fr_idx + 1 < fr_len) begin
        fr_idx = fr_idx + 9'd1;
      end else begin
        fr_phase = PH_HUNT;
        fr_idx = '0;
        // Short frames and foreign packet types end without a report.
        if (fr_len >= MIN_FRAME && cap_type == shadow_cfg.packet_type) begin
          rpt.fresh = (cap_kind == shadow_cfg.sensor_kind);
          if (rpt.fresh) stored_dist = 11'((int'(cap_reading) * 544) / 100);
          rpt.distance = stored_dist;
          rpt.level = level_of(stored_dist);
          level_reports_due.push_back(rpt);
        end
      end
    end
  endfunction

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Queue one frame for the current settings; cut_at truncates it.
  task automatic queue_frame(input logic [7:0] len_b, input logic [7:0] typ,
                             input logic [7:0] kind_b, input logic [7:0] reading,
                             input int cut_at);
    int total;
    logic [7:0] b;
    total = int'(len_b) + 3;
    if (cut_at < total) total = cut_at;
    for (int ofs = 0; ofs < total; ofs++) begin
      case (ofs)
        0: b = gen_cfg.start_byte;
        1: b = len_b;
        OFS_TYPE: b = typ;
        OFS_KIND: b = kind_b;
        OFS_READING: b = reading;
        default: b = ($urandom_range(0, 15) == 0) ? gen_cfg.start_byte : 8'($urandom);
      endcase
      byte_q.push_back(b);
    end
    queued_bytes += total;
  endtask

  // Mostly well-formed frames with random content, plus noise and cut frames.
  task automatic queue_random_traffic(input int n_bytes, input int min_hits);
    int start_count;
    int hits;
    int sel;
    logic [7:0] len_b;
    logic [7:0] typ;
    logic [7:0] kind_b;
    logic [7:0] reading;
    start_count = queued_bytes;
    hits = 0;
    while (queued_bytes - start_count < n_bytes || hits < min_hits) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        repeat ($urandom_range(1, 4)) begin
          byte_q.push_back(8'($urandom));
          queued_bytes++;
        end
      end else if (sel < 14) begin
        len_b = 8'($urandom_range(11, 24));
        queue_frame(len_b, gen_cfg.packet_type, 8'($urandom), 8'($urandom),
                    $urandom_range(2, int'(len_b) + 2));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 10) len_b = 8'($urandom_range(0, 10));
        else if (sel < 97) len_b = 8'($urandom_range(11, 24));
        else len_b = 8'($urandom_range(25, 255));
        typ = ($urandom_range(0, 3) != 0) ? gen_cfg.packet_type : 8'($urandom);
        kind_b = ($urandom_range(0, 9) < 7) ? {5'($urandom), gen_cfg.sensor_kind}
                                            : 8'($urandom);
        reading = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 9))
                                              : 8'($urandom);
        queue_frame(len_b, typ, kind_b, reading, 1000);
        if (len_b >= 8'd11 && typ == gen_cfg.packet_type) hits++;
      end
    end
  endtask

  // Write all three registers on consecutive edges while the block is idle.
  task automatic write_regs(input logic [7:0] sb, input logic [7:0] pt,
                            input logic [7:0] sk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_BYTE;
    cfg_wdata <= sb;
    @(posedge clk);
    cfg_index <= REG_PACKET_TYPE;
    cfg_wdata <= pt;
    @(posedge clk);
    cfg_index <= REG_SENSOR_KIND;
    cfg_wdata <= sk;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_cfg.start_byte = sb;
    gen_cfg.packet_type = pt;
    gen_cfg.sensor_kind = sk[2:0];
    @(negedge clk);
  endtask

  // Wait until every byte went in and every report came out, then settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_push || level_reports_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: tracks register writes, predicts on each accepted request,
  // and offers bytes in bursts separated by random gaps unless held steady.
  always @(posedge clk) begin
    if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:  shadow_cfg.start_byte = cfg_wdata;
        REG_PACKET_TYPE: shadow_cfg.packet_type = cfg_wdata;
        REG_SENSOR_KIND: shadow_cfg.sensor_kind = cfg_wdata[2:0];
        default: ;
      endcase
    end
    if (in_push && in_full) full_stalls++;
    if (in_push && !in_full) begin
      parse_rx_byte(in_rx_byte);
      bytes_sent++;
    end
    if (!in_push || !in_full) begin
      if (gap_left != 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_push <= 1'b1;
        in_rx_byte <= byte_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = (sender_steady || $urandom_range(0, 2) == 0) ? 0
                                                                 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted result against the oldest expectation,
  // and pops on a repeating random mask or holds off on request.
  always @(posedge clk) begin : receiver
    level_report_t want;
    if (out_pop && !out_empty) begin
      if (level_reports_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result level %0d distance %0d updated %0d",
                                out_level, out_distance, out_distance_updated));
      end else begin
        want = level_reports_due.pop_front();
        if (out_level !== want.level)
          note_mismatch($sformatf("level %0d, expected %0d", out_level, want.level));
        if (out_distance !== want.distance)
          note_mismatch($sformatf("distance %0d, expected %0d",
                                  out_distance, want.distance));
        if (out_distance_updated !== want.fresh)
          note_mismatch($sformatf("distance_updated %0d, expected %0d",
                                  out_distance_updated, want.fresh));
        reports_checked++;
        if (want.fresh) fresh_readings++;
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else begin
      if (pat_pos == 0) pop_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      out_pop <= pop_mask[pat_pos[2:0]];
      pat_pos <= pat_pos + 6'd1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sensor_frame_distance_level test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: full reading with start value inside the frame,
    // the shortest possible frame, then bytes that only hunt.
    byte_q = {8'h02, 8'd11, 8'h02, 8'h02, 8'h00, 8'hFF, 8'h02, 8'h01,
              8'h55, 8'hAA, 8'hFA, 8'h02, 8'h00, 8'hFF,
              8'h02, 8'h00, 8'h7E,
              8'h00, 8'hFF};
    queued_bytes += 19;
    queue_random_traffic(150, 8);
    wait_drained();

    // Lowest register values.
    write_regs(8'h00, 8'h00, 8'h00);
    queue_random_traffic(170, 8);
    wait_drained();

    // Highest values; the kind write carries bits above its width.
    sender_steady = 1'b1;
    write_regs(8'hFF, 8'hFF, 8'hFF);
    queue_random_traffic(170, 8);
    wait_drained();

    // Long receiver hold against a steady sender, so the input backs up.
    write_regs(8'($urandom), 8'($urandom), 8'($urandom));
    hold_request = 1'b1;
    queue_random_traffic(170, 10);
    wait_drained();

    sender_steady = 1'b0;
    write_regs(8'($urandom), 8'($urandom), 8'($urandom));
    queue_random_traffic(170, 8);
    wait_drained();

    $display("Sent %0d bytes over five register settings; %0d level reports checked,",
             bytes_sent, reports_checked);
    $display("%0d with a fresh reading; input held back by a full block on %0d cycles.",
             fresh_readings, full_stalls);
    if (mismatch_count == 0) begin
      $display("sensor_frame_distance_level test passed");
    end else begin
      $display("sensor_frame_distance_level test failed");
    end
    $finish;
  end

endmodule

// ===== sensor_frame_distance_level.f =====
hdl/sfdl_pkg.sv
hdl/sfdl_front.sv
hdl/sfdl_fifo.sv
hdl/sfdl_back.sv
hdl/sensor_frame_distance_level.sv
sim/tb_sensor_frame_distance_level.sv
